// File: rtl/core/led_error_code_blinker_unit_macros.svh
// ----------------------------------------------------------------------------
// LED error code blinker assertion macros
// Shared concurrent assertion forms for the blinker checker.
// ----------------------------------------------------------------------------
`ifndef LED_ERROR_CODE_BLINKER_UNIT_MACROS_SVH
`define LED_ERROR_CODE_BLINKER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LECB_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("blinker assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define LECB_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("blinker assertion failed");

`endif

// File: rtl/core/lecb_pkg.sv
// ----------------------------------------------------------------------------
// LED error code blinker package
// Types, register indexes and reset values shared by the blinker modules.
// ----------------------------------------------------------------------------
package lecb_pkg;

  localparam int unsigned CodeBitsDef   = 32;
  localparam int unsigned CountWidthDef = 24;
  localparam int unsigned CfgWidth      = 24;
  localparam int unsigned CfgIdxWidth   = 3;

  localparam logic [0:0] OP_TICK  = 1'b0;
  localparam logic [0:0] OP_START = 1'b1;

  localparam logic [23:0] GAP_TICKS_RST        = 24'd1000000;
  localparam logic [23:0] BLINK_HALF_TICKS_RST = 24'd50000;
  localparam logic [3:0]  BLINK_COUNT_RST      = 4'd10;
  localparam logic [23:0] BIT_PERIOD_TICKS_RST = 24'd2000000;
  localparam logic [23:0] LONG_ON_TICKS_RST    = 24'd1600000;
  localparam logic [23:0] SHORT_ON_TICKS_RST   = 24'd400000;

  typedef enum logic [CfgIdxWidth-1:0] {
    CFG_GAP_TICKS        = 3'd0,
    CFG_BLINK_HALF_TICKS = 3'd1,
    CFG_BLINK_COUNT      = 3'd2,
    CFG_BIT_PERIOD_TICKS = 3'd3,
    CFG_LONG_ON_TICKS    = 3'd4,
    CFG_SHORT_ON_TICKS   = 3'd5
  } lecb_cfg_idx_e;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_GAP1      = 3'd1,
    PH_BLINK_ON  = 3'd2,
    PH_BLINK_OFF = 3'd3,
    PH_GAP2      = 3'd4,
    PH_BIT_ON    = 3'd5,
    PH_BIT_OFF   = 3'd6
  } lecb_phase_e;

  typedef struct packed {
    logic [0:0]  op;
    logic [31:0] error_code;
  } lecb_req_t;

  typedef struct packed {
    logic [0:0] led_on;
    logic [0:0] busy_res;
    logic [0:0] finished;
  } lecb_res_t;

  typedef struct packed {
    logic [23:0] gap_ticks;
    logic [23:0] blink_half_ticks;
    logic [3:0]  blink_count;
    logic [23:0] bit_period_ticks;
    logic [23:0] long_on_ticks;
    logic [23:0] short_on_ticks;
  } lecb_cfg_t;

endpackage

// File: rtl/core/lecb_cfg_regs.sv
// ----------------------------------------------------------------------------
// LED error code blinker configuration registers
// Holds the six timing registers written through the plain write port.
// ----------------------------------------------------------------------------
module lecb_cfg_regs (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [lecb_pkg::CfgIdxWidth-1:0]       cfg_idx_i,
  input  logic [lecb_pkg::CfgWidth-1:0]          cfg_wdata_i,
  output lecb_pkg::lecb_cfg_t                    cfg_o
);
  import lecb_pkg::*;

  lecb_cfg_t cfg_q;
  lecb_cfg_t cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GAP_TICKS:        cfg_d.gap_ticks        = cfg_wdata_i;
        CFG_BLINK_HALF_TICKS: cfg_d.blink_half_ticks = cfg_wdata_i;
        CFG_BLINK_COUNT:      cfg_d.blink_count      = cfg_wdata_i[3:0];
        CFG_BIT_PERIOD_TICKS: cfg_d.bit_period_ticks = cfg_wdata_i;
        CFG_LONG_ON_TICKS:    cfg_d.long_on_ticks    = cfg_wdata_i;
        CFG_SHORT_ON_TICKS:   cfg_d.short_on_ticks   = cfg_wdata_i;
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gap_ticks        <= GAP_TICKS_RST;
      cfg_q.blink_half_ticks <= BLINK_HALF_TICKS_RST;
      cfg_q.blink_count      <= BLINK_COUNT_RST;
      cfg_q.bit_period_ticks <= BIT_PERIOD_TICKS_RST;
      cfg_q.long_on_ticks    <= LONG_ON_TICKS_RST;
      cfg_q.short_on_ticks   <= SHORT_ON_TICKS_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: rtl/core/lecb_seq.sv
// ----------------------------------------------------------------------------
// LED error code blinker sequencer
// Phase, tick counter, blink counter, bit index and stored code, stepped once
// per request, with the result of that request.
// ----------------------------------------------------------------------------
module lecb_seq #(
  parameter int unsigned CODE_BITS   = lecb_pkg::CodeBitsDef,
  parameter int unsigned COUNT_WIDTH = lecb_pkg::CountWidthDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  step_i,
  input  lecb_pkg::lecb_req_t   req_i,
  input  lecb_pkg::lecb_cfg_t   cfg_i,
  output lecb_pkg::lecb_res_t   res_o
);
  import lecb_pkg::*;

  localparam int unsigned IdxWidth = (CODE_BITS > 1) ? $clog2(CODE_BITS) : 1;

  lecb_phase_e            phase_q, phase_d;
  logic [COUNT_WIDTH-1:0] tick_q, tick_d;
  logic [3:0]             blinks_q, blinks_d;
  logic [IdxWidth-1:0]    bit_idx_q, bit_idx_d;
  logic [CODE_BITS-1:0]   code_q, code_d;

  logic [COUNT_WIDTH-1:0] gap_len, half_len, per_len, on_len, off_len, seg_len;
  logic [COUNT_WIDTH-1:0] tick_nxt;
  logic [3:0]             blinks_nxt;
  logic                   fin;

  function automatic logic [COUNT_WIDTH-1:0] at_least_one(input logic [CfgWidth-1:0] v);
    logic [COUNT_WIDTH-1:0] c;
    c = COUNT_WIDTH'(v);
    return (c == '0) ? COUNT_WIDTH'(1) : c;
  endfunction

  always_comb begin
    gap_len  = at_least_one(cfg_i.gap_ticks);
    half_len = at_least_one(cfg_i.blink_half_ticks);
    per_len  = COUNT_WIDTH'(cfg_i.bit_period_ticks);
    on_len   = code_q[bit_idx_q] ? at_least_one(cfg_i.long_on_ticks)
                                 : at_least_one(cfg_i.short_on_ticks);
    off_len  = (per_len > on_len) ? (per_len - on_len) : '0;

    case (phase_q)
      PH_GAP1, PH_GAP2:          seg_len = gap_len;
      PH_BLINK_ON, PH_BLINK_OFF: seg_len = half_len;
      PH_BIT_ON:                 seg_len = on_len;
      PH_BIT_OFF:                seg_len = off_len;
      default:                   seg_len = COUNT_WIDTH'(1);
    endcase

    tick_nxt   = tick_q + COUNT_WIDTH'(1);
    blinks_nxt = blinks_q + 4'd1;

    phase_d   = phase_q;
    tick_d    = tick_q;
    blinks_d  = blinks_q;
    bit_idx_d = bit_idx_q;
    code_d    = code_q;
    fin       = 1'b0;

    if (step_i) begin
      if (req_i.op == OP_START) begin
        if (phase_q == PH_IDLE) begin
          code_d    = CODE_BITS'(req_i.error_code);
          phase_d   = PH_GAP1;
          tick_d    = '0;
          blinks_d  = '0;
          bit_idx_d = '0;
        end
      end else if (phase_q != PH_IDLE) begin
        if ((tick_nxt == '0) || (tick_nxt >= seg_len)) begin
          tick_d = '0;
          case (phase_q)
            PH_GAP1: begin
              blinks_d = '0;
              phase_d  = (cfg_i.blink_count != 4'd0) ? PH_BLINK_ON : PH_GAP2;
            end
            PH_BLINK_ON: begin
              phase_d = PH_BLINK_OFF;
            end
            PH_BLINK_OFF: begin
              blinks_d = blinks_nxt;
              phase_d  = ((blinks_nxt == 4'd0) || (blinks_nxt >= cfg_i.blink_count))
                         ? PH_GAP2 : PH_BLINK_ON;
            end
            PH_GAP2: begin
              bit_idx_d = IdxWidth'(CODE_BITS - 1);
              phase_d   = PH_BIT_ON;
            end
            PH_BIT_ON, PH_BIT_OFF: begin
              if ((phase_q == PH_BIT_ON) && (off_len != '0)) begin
                phase_d = PH_BIT_OFF;
              end else if (bit_idx_q == '0) begin
                phase_d = PH_IDLE;
                code_d  = '0;
                fin     = 1'b1;
              end else begin
                bit_idx_d = bit_idx_q - IdxWidth'(1);
                phase_d   = PH_BIT_ON;
              end
            end
            default: begin
              phase_d = PH_IDLE;
            end
          endcase
        end else begin
          tick_d = tick_nxt;
        end
      end
    end

    res_o.led_on   = ((phase_d == PH_BLINK_ON) || (phase_d == PH_BIT_ON)) ? 1'b1 : 1'b0;
    res_o.busy_res = (phase_d != PH_IDLE) ? 1'b1 : 1'b0;
    res_o.finished = fin;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      tick_q    <= '0;
      blinks_q  <= '0;
      bit_idx_q <= '0;
      code_q    <= '0;
    end else begin
      phase_q   <= phase_d;
      tick_q    <= tick_d;
      blinks_q  <= blinks_d;
      bit_idx_q <= bit_idx_d;
      code_q    <= code_d;
    end
  end

endmodule

// File: rtl/core/led_error_code_blinker_unit.sv
// ----------------------------------------------------------------------------
// LED error code blinker unit
// The request channel carries either a start request with a 32-bit error code
// or a tick request, normally one per microsecond. Every request produces one
// result on the result channel: the LED level, a busy flag and a finished flag
// that is set only on the tick that ends the display sequence.
// A start request while a sequence is running is ignored and only reports the
// current state. The six timing registers are written through a plain write
// port and may only be changed while no request is in flight.
// A request is captured in the input register when it is accepted, and its
// result is loaded into the result register when the sequencer steps on it.
// Throughput is one request per cycle while the receiver does not stall, as
// the sequencer state registers update on every step. When the receiver
// stalls, the result register holds its content and the input register
// holds one more request; the request channel then stops accepting until the
// result is taken. Reset clears both valid flags, puts the sequencer in idle
// with a cleared code and loads the timing registers with their defaults.
// ----------------------------------------------------------------------------
module led_error_code_blinker_unit #(
  parameter int unsigned CODE_BITS   = lecb_pkg::CodeBitsDef,
  parameter int unsigned COUNT_WIDTH = lecb_pkg::CountWidthDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  lecb_pkg::lecb_req_t                in_req_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output lecb_pkg::lecb_res_t                out_res_o,
  input  logic                               cfg_we_i,
  input  logic [lecb_pkg::CfgIdxWidth-1:0]   cfg_idx_i,
  input  logic [lecb_pkg::CfgWidth-1:0]      cfg_wdata_i
);
  import lecb_pkg::*;

  lecb_cfg_t cfg;
  lecb_res_t res_d;
  lecb_req_t req_q;
  lecb_res_t res_q;
  logic      req_valid_q;
  logic      res_valid_q;
  logic      advance;
  logic      step;

  assign advance    = !res_valid_q || out_ready_i;
  assign step       = req_valid_q && advance;
  assign in_ready_o = !req_valid_q || advance;

  lecb_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cfg_o      (cfg)
  );

  lecb_seq #(
    .CODE_BITS  (CODE_BITS),
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_seq (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .step_i(step),
    .req_i (req_q),
    .cfg_i (cfg),
    .res_o (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid_q <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        req_valid_q <= in_valid_i;
      end
      if (advance) begin
        res_valid_q <= req_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q <= in_req_i;
    end
    if (step) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = res_valid_q;
  assign out_res_o   = res_q;

endmodule

// File: rtl/core/lecb_checker.sv
// ----------------------------------------------------------------------------
// LED error code blinker port checker
// Port-level assertions on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "led_error_code_blinker_unit_macros.svh"

module lecb_checker (
  input logic                               clk_i,
  input logic                               rst_ni,
  input logic                               out_valid_o,
  input logic                               out_ready_i,
  input lecb_pkg::lecb_res_t                out_res_o
);
  import lecb_pkg::*;

  // A finished result always reports an idle, dark LED.
  `LECB_ASSERT_IMP(a_fin_idle, clk_i, rst_ni, out_valid_o && out_res_o.finished,
    !out_res_o.led_on && !out_res_o.busy_res)

  // The LED is only lit while a sequence is running.
  `LECB_ASSERT_IMP(a_led_busy, clk_i, rst_ni, out_valid_o && out_res_o.led_on,
    out_res_o.busy_res)

  // A stalled result stays offered.
  `LECB_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)

  // A stalled result keeps its value.
  `LECB_ASSERT_NXT(a_out_stable, clk_i, rst_ni, out_valid_o && !out_ready_i,
    $stable(out_res_o))

endmodule

bind led_error_code_blinker_unit lecb_checker u_lecb_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .out_valid_o(out_valid_o),
  .out_ready_i(out_ready_i),
  .out_res_o  (out_res_o)
);

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// LED error code blinker unit testbench
// Drives start and tick requests through the valid/ready request channel and
// checks every result against a cycle-free model of the blink sequencer. The
// timing registers are reloaded between runs while the unit is idle. Random
// pauses on both channels, a long result hold-off and a drained pause on the
// request side exercise the handshakes.
// ----------------------------------------------------------------------------
module tb;
  import lecb_pkg::*;

  localparam logic [CfgIdxWidth-1:0] CFG_IDX_SPARE_LO = 3'd6;
  localparam logic [CfgIdxWidth-1:0] CFG_IDX_SPARE_HI = 3'd7;
  localparam logic [CfgWidth-1:0]    CFG_MAX          = 24'hFFFFFF;
  localparam int unsigned            RANDOM_REQUESTS  = 600;
  localparam int unsigned            STALL_LIMIT      = 2000;

  logic                   clk_i;
  logic                   rst_ni;
  logic                   in_valid_i;
  logic                   in_ready_o;
  lecb_req_t              in_req_i;
  logic                   out_valid_o;
  logic                   out_ready_i;
  lecb_res_t              out_res_o;
  logic                   cfg_we_i;
  logic [CfgIdxWidth-1:0] cfg_idx_i;
  logic [CfgWidth-1:0]    cfg_wdata_i;

  // Model state of the sequencer.
  lecb_cfg_t     timing;
  lecb_phase_e   seq_phase;
  logic [23:0]   seg_ticks;
  logic [3:0]    blinks_shown;
  logic [4:0]    bit_pos;
  logic [31:0]   shown_code;

  lecb_res_t     expected_led_q[$];
  int unsigned   error_count;
  int unsigned   requests_sent;
  int unsigned   idle_edges;
  int unsigned   rx_hold_cycles;
  int unsigned   rx_stall_left;
  bit            tx_idle_en;
  bit            rx_idle_en;

  led_error_code_blinker_unit u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_res_o   (out_res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic logic [23:0] min_one_tick(logic [23:0] v);
    return (v == '0) ? 24'd1 : v;
  endfunction

  function automatic logic [23:0] bit_on_len();
    logic one;
    one = shown_code[bit_pos];
    return min_one_tick(one ? timing.long_on_ticks : timing.short_on_ticks);
  endfunction

  function automatic logic [23:0] bit_off_len();
    logic [23:0] on_len;
    on_len = bit_on_len();
    return (timing.bit_period_ticks > on_len) ? timing.bit_period_ticks - on_len : '0;
  endfunction

  function automatic logic [23:0] segment_len();
    case (seq_phase)
      PH_GAP1, PH_GAP2:          return min_one_tick(timing.gap_ticks);
      PH_BLINK_ON, PH_BLINK_OFF: return min_one_tick(timing.blink_half_ticks);
      PH_BIT_ON:                 return bit_on_len();
      PH_BIT_OFF:                return bit_off_len();
      default:                   return 24'd1;
    endcase
  endfunction

  // Moves to the next code bit, or ends the sequence after the last one.
  function automatic logic finish_bit();
    if (bit_pos == '0) begin
      seq_phase  = PH_IDLE;
      shown_code = '0;
      return 1'b1;
    end
    bit_pos   = bit_pos - 5'd1;
    seq_phase = PH_BIT_ON;
    return 1'b0;
  endfunction

  function automatic logic next_segment();
    seg_ticks = '0;
    case (seq_phase)
      PH_GAP1: begin
        blinks_shown = '0;
        if (timing.blink_count != '0) begin
          seq_phase = PH_BLINK_ON;
        end else begin
          seq_phase = PH_GAP2;
        end
      end
      PH_BLINK_ON: begin
        seq_phase = PH_BLINK_OFF;
      end
      PH_BLINK_OFF: begin
        blinks_shown = blinks_shown + 4'd1;
        if (blinks_shown == '0 || blinks_shown >= timing.blink_count) begin
          seq_phase = PH_GAP2;
        end else begin
          seq_phase = PH_BLINK_ON;
        end
      end
      PH_GAP2: begin
        bit_pos   = 5'(CodeBitsDef - 1);
        seq_phase = PH_BIT_ON;
      end
      PH_BIT_ON: begin
        if (bit_off_len() != '0) begin
          seq_phase = PH_BIT_OFF;
        end else begin
          return finish_bit();
        end
      end
      PH_BIT_OFF: begin
        return finish_bit();
      end
      default: begin
        seq_phase = PH_IDLE;
      end
    endcase
    return 1'b0;
  endfunction

  function automatic lecb_res_t next_led_state(lecb_req_t req);
    lecb_res_t   res;
    logic        fin;
    logic [23:0] nxt;
    fin = 1'b0;
    if (req.op == OP_START) begin
      if (seq_phase == PH_IDLE) begin
        shown_code   = req.error_code;
        seq_phase    = PH_GAP1;
        seg_ticks    = '0;
        blinks_shown = '0;
        bit_pos      = '0;
      end
    end else if (seq_phase != PH_IDLE) begin
      nxt = seg_ticks + 24'd1;
      if (nxt == '0 || nxt >= segment_len()) begin
        fin = next_segment();
      end else begin
        seg_ticks = nxt;
      end
    end
    res.led_on   = (seq_phase == PH_BLINK_ON || seq_phase == PH_BIT_ON);
    res.busy_res = (seq_phase != PH_IDLE);
    res.finished = fin;
    return res;
  endfunction

  function automatic int unsigned pick_pause(bit enabled);
    int unsigned r;
    if (!enabled) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 40);
  endfunction

  function automatic logic [23:0] pick_length();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 60) return 24'($urandom_range(1, 2));
    if (r < 95) return 24'($urandom_range(3, 5));
    return 24'($urandom_range(6, 12));
  endfunction

  function automatic logic [31:0] pick_code();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 10) return '1;
    if (r < 20) return '0;
    return $urandom();
  endfunction

  function automatic void check_field(string name, logic exp_bit, logic act_bit);
    if (exp_bit !== act_bit) begin
      $display("%0t: %s mismatch, expected %0b, got %0b", $time, name, exp_bit, act_bit);
      error_count++;
    end
  endfunction

  // Offers one request and returns at the edge that accepts it.
  task automatic send_request(input logic [0:0] op, input logic [31:0] code);
    int unsigned pause;
    lecb_req_t   req;
    pause        = pick_pause(tx_idle_en);
    req.op       = op;
    req.error_code = code;
    @(negedge clk_i);
    if (pause != 0) begin
      in_valid_i = 1'b0;
      repeat (pause) @(negedge clk_i);
    end
    in_valid_i = 1'b1;
    in_req_i   = req;
    do @(posedge clk_i); while (!in_ready_o);
    expected_led_q.push_back(next_led_state(req));
    requests_sent++;
  endtask

  task automatic settle_idle();
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_led_q.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic write_timing(input logic [CfgIdxWidth-1:0] idx,
                              input logic [CfgWidth-1:0] data);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_idx_i   = idx;
    cfg_wdata_i = data;
    case (idx)
      CFG_GAP_TICKS:        timing.gap_ticks        = data;
      CFG_BLINK_HALF_TICKS: timing.blink_half_ticks = data;
      CFG_BLINK_COUNT:      timing.blink_count      = data[3:0];
      CFG_BIT_PERIOD_TICKS: timing.bit_period_ticks = data;
      CFG_LONG_ON_TICKS:    timing.long_on_ticks    = data;
      CFG_SHORT_ON_TICKS:   timing.short_on_ticks   = data;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i = 1'b0;
  endtask

  task automatic load_timing(input logic [23:0] gap, input logic [23:0] half,
                             input logic [23:0] count, input logic [23:0] period,
                             input logic [23:0] long_on, input logic [23:0] short_on);
    settle_idle();
    write_timing(CFG_GAP_TICKS, gap);
    write_timing(CFG_BLINK_HALF_TICKS, half);
    write_timing(CFG_BLINK_COUNT, count);
    write_timing(CFG_BIT_PERIOD_TICKS, period);
    write_timing(CFG_LONG_ON_TICKS, long_on);
    write_timing(CFG_SHORT_ON_TICKS, short_on);
  endtask

  // Ticks until the sequence ends, with an occasional start that must be ignored.
  task automatic finish_display();
    while (seq_phase != PH_IDLE) begin
      if ($urandom_range(0, 99) < 3) begin
        send_request(OP_START, $urandom());
      end else begin
        send_request(OP_TICK, $urandom());
      end
    end
  endtask

  task automatic play_code(input logic [31:0] code);
    repeat ($urandom_range(0, 2)) send_request(OP_TICK, $urandom());
    send_request(OP_START, code);
    finish_display();
  endtask

  task automatic test_idle_ticks();
    send_request(OP_TICK, '1);
    send_request(OP_TICK, '0);
    repeat (4) send_request(OP_TICK, $urandom());
  endtask

  task automatic test_basic_code();
    load_timing(24'd2, 24'd1, 24'd2, 24'd3, 24'd2, 24'd1);
    send_request(OP_START, 32'hFFFF_FFFF);
    send_request(OP_START, 32'h0000_0000);
    finish_display();
    play_code(32'h0000_0000);
    play_code(32'h8000_0001);
  endtask

  task automatic test_no_blinks();
    load_timing(24'd3, 24'd2, 24'd0, 24'd2, 24'd1, 24'd1);
    play_code(32'h5555_AAAA);
  endtask

  task automatic test_zero_off_time();
    load_timing(24'd2, 24'd1, 24'd1, 24'd3, 24'd3, 24'd5);
    play_code(32'hA5A5_0F0F);
    load_timing(24'd1, 24'd1, 24'd1, 24'd4, 24'd6, 24'd1);
    play_code(32'h0F0F_A5A5);
  endtask

  task automatic test_zero_lengths();
    load_timing(24'd0, 24'd0, 24'd3, 24'd0, 24'd0, 24'd0);
    play_code($urandom());
  endtask

  task automatic test_max_blinks();
    // Upper data bits of the count write are dropped by the register.
    load_timing(24'd1, 24'd1, 24'hABCDEF, 24'd2, 24'd1, 24'd1);
    play_code($urandom());
  endtask

  task automatic test_register_limits();
    load_timing(CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX, CFG_MAX);
    repeat (5) send_request(OP_TICK, $urandom());
    load_timing(24'd1, 24'd2, 24'd1, 24'd3, 24'd2, 24'd1);
    write_timing(CFG_IDX_SPARE_LO, CFG_MAX);
    write_timing(CFG_IDX_SPARE_HI, 24'($urandom()));
    play_code($urandom());
  endtask

  task automatic test_backpressure();
    load_timing(24'd2, 24'd1, 24'd2, 24'd2, 24'd1, 24'd1);
    tx_idle_en     = 1'b0;
    rx_hold_cycles = 80;
    send_request(OP_START, $urandom());
    repeat (40) send_request(OP_TICK, $urandom());
    // Let the result side drain completely before ticking on.
    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (expected_led_q.size() != 0) @(negedge clk_i);
    finish_display();
    tx_idle_en = 1'b1;
  endtask

  task automatic test_random_codes();
    int unsigned stop_at;
    stop_at = requests_sent + RANDOM_REQUESTS;
    while (requests_sent < stop_at) begin
      settle_idle();
      write_timing(CFG_GAP_TICKS,
                   ($urandom_range(0, 19) == 0) ? 24'($urandom_range(40, 200)) : pick_length());
      write_timing(CFG_BLINK_HALF_TICKS, pick_length());
      write_timing(CFG_BLINK_COUNT, 24'($urandom()));
      write_timing(CFG_BIT_PERIOD_TICKS, pick_length());
      write_timing(CFG_LONG_ON_TICKS, pick_length());
      write_timing(CFG_SHORT_ON_TICKS, pick_length());
      tx_idle_en = ($urandom_range(0, 3) != 0);
      rx_idle_en = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(1, 2)) play_code(pick_code());
    end
    tx_idle_en = 1'b1;
    rx_idle_en = 1'b1;
  endtask

  initial begin
    out_ready_i   = 1'b0;
    rx_stall_left = 0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (rx_hold_cycles > 0) begin
        out_ready_i = 1'b0;
        rx_hold_cycles--;
      end else if (rx_stall_left > 0) begin
        out_ready_i = 1'b0;
        rx_stall_left--;
      end else begin
        out_ready_i   = 1'b1;
        rx_stall_left = pick_pause(rx_idle_en);
      end
    end
  end

  always @(posedge clk_i) begin
    lecb_res_t exp_res;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_led_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %b", $time, out_res_o);
        error_count++;
      end else begin
        exp_res = expected_led_q.pop_front();
        check_field("led_on", exp_res.led_on, out_res_o.led_on);
        check_field("busy_res", exp_res.busy_res, out_res_o.busy_res);
        check_field("finished", exp_res.finished, out_res_o.finished);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      idle_edges <= 0;
    end else begin
      idle_edges <= idle_edges + 1;
    end
    if (idle_edges >= STALL_LIMIT) begin
      $display("%0t: no progress for %0d cycles", $time, idle_edges);
      $display("** led_error_code_blinker_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    rst_ni         = 1'b0;
    in_valid_i     = 1'b0;
    in_req_i       = '0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_wdata_i    = '0;
    error_count    = 0;
    requests_sent  = 0;
    idle_edges     = 0;
    rx_hold_cycles = 0;
    tx_idle_en     = 1'b1;
    rx_idle_en     = 1'b1;
    timing.gap_ticks        = GAP_TICKS_RST;
    timing.blink_half_ticks = BLINK_HALF_TICKS_RST;
    timing.blink_count      = BLINK_COUNT_RST;
    timing.bit_period_ticks = BIT_PERIOD_TICKS_RST;
    timing.long_on_ticks    = LONG_ON_TICKS_RST;
    timing.short_on_ticks   = SHORT_ON_TICKS_RST;
    seq_phase    = PH_IDLE;
    seg_ticks    = '0;
    blinks_shown = '0;
    bit_pos      = '0;
    shown_code   = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_idle_ticks();
    test_basic_code();
    test_no_blinks();
    test_zero_off_time();
    test_zero_lengths();
    test_max_blinks();
    test_register_limits();
    test_backpressure();
    test_random_codes();

    settle_idle();
    repeat (10) @(posedge clk_i);
    if (error_count == 0 && expected_led_q.size() == 0) begin
      $display("** led_error_code_blinker_unit: PASSED **");
    end else begin
      $display("** led_error_code_blinker_unit: FAILED **");
    end
    $finish;
  end

endmodule
